/* sv/smau_pkg.sv */
// shared constants, codes and types of the stack machine arithmetic unit
package smau_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned OPCODE_W        = 3;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned COUNT_W         = 7;
  localparam int unsigned STACK_DEPTH_DEF = 64;

  // instruction codes
  localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_MOD  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SWAP = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FEW     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd4;

  // what a stack cell loads on the next edge
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_TAKE_UP,
    CM_TAKE_DN
  } cell_mode_t;

  // divider result handed back to the controller
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* sv/smau_if.sv */
// valid/ready channel interfaces for instructions and results
interface smau_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [smau_pkg::OPCODE_W-1:0]        opcode;
  logic signed [smau_pkg::WORD_W-1:0]   push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface smau_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [smau_pkg::STATUS_W-1:0]        status;
  logic signed [smau_pkg::WORD_W-1:0]   top_value;
  logic [smau_pkg::COUNT_W-1:0]         stack_count;

  modport source (output valid, output status, output top_value, output stack_count,
                  input ready);
  modport sink   (input valid, input status, input top_value, input stack_count,
                  output ready);
endinterface

/* sv/smau_cell.sv */
// one stack cell: holds one entry and takes a neighbor's entry on a shift
module smau_cell (
  input  logic                          clk,
  input  smau_pkg::cell_mode_t          mode,
  input  logic [smau_pkg::WORD_W-1:0]   up_in,
  input  logic [smau_pkg::WORD_W-1:0]   dn_in,
  output logic [smau_pkg::WORD_W-1:0]   value
);

  logic [smau_pkg::WORD_W-1:0] value_r;
  logic [smau_pkg::WORD_W-1:0] value_nxt;

  always_comb begin
    case (mode)
      smau_pkg::CM_TAKE_UP: value_nxt = up_in;
      smau_pkg::CM_TAKE_DN: value_nxt = dn_in;
      default:              value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

/* sv/smau_div.sv */
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module smau_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [smau_pkg::WORD_W-1:0]   dividend,
  input  logic [smau_pkg::WORD_W-1:0]   divisor,
  output smau_pkg::div_rsp_t            rsp
);

  localparam int unsigned W  = smau_pkg::WORD_W;
  localparam int unsigned IW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic          qneg_r, qneg_nxt;
  logic          rneg_r, rneg_nxt;

  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      rem_nxt  = '0;
      // magnitudes; the most negative value maps onto itself as unsigned
      quo_nxt  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
      dvs_nxt  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
      qneg_nxt = dividend[W-1] ^ divisor[W-1];
      rneg_nxt = dividend[W-1];
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      iter_nxt = iter_r + IW'(1);
      if (iter_r == IW'(W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    iter_r <= iter_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = qneg_r ? (~quo_r + W'(1)) : quo_r;
  assign rsp.remainder = rneg_r ? (~rem_r + W'(1)) : rem_r;

endmodule

/* sv/stack_machine_arith_unit.sv */
// top level: stack machine arithmetic unit built on a row of shifting stack cells
//
//   channel | direction | payload                              | handshake
//   in_ch   | in        | opcode, push_value                   | valid/ready
//   out_ch  | out       | status, top_value, stack_count       | valid/ready
//
// one instruction at a time: push, sub, swap and unused opcodes pass through the exec
// and resp states, mul adds a state for the registered product, div and mod wait in
// the div state for the 32 iterations of the one-bit-per-cycle divider.
// the next instruction is accepted while a result still waits in the output register.
// synchronous active-low reset empties the stack and clears the halt; entries need no
// clearing since only entries below the count are read.
module stack_machine_arith_unit #(
  parameter int unsigned STACK_DEPTH = smau_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  smau_in_if.sink    in_ch,
  smau_out_if.source out_ch
);

  localparam int unsigned W  = smau_pkg::WORD_W;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_PUSH,
    ACT_POP,
    ACT_SWAP
  } stk_act_t;

  state_t                          state_r, state_nxt;
  logic [smau_pkg::OPCODE_W-1:0]   op_r;
  logic [W-1:0]                    val_r;
  logic [smau_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic                            halted_r, halted_nxt;
  logic [W-1:0]                    mul_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [smau_pkg::STATUS_W-1:0]   out_status_r;
  logic [W-1:0]                    out_top_r;
  logic [smau_pkg::COUNT_W-1:0]    out_count_r;
  logic                            out_load;

  stk_act_t                        stk_act;
  logic [W-1:0]                    stk_data;
  logic                            div_start;
  smau_pkg::div_rsp_t              div_rsp;

  logic [W-1:0]                    cell_q [STACK_DEPTH];
  logic [W-1:0]                    top_b;
  logic [W-1:0]                    second_a;
  logic [W-1:0]                    product;
  logic [CW+6:0]                   cnt_ext;

  assign top_b    = cell_q[0];
  assign second_a = cell_q[1];
  // low half only, the product wraps
  assign product  = top_b * second_a;
  assign cnt_ext  = {7'd0, cnt_r};

  // row of stack cells, entry 0 is the top
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    smau_pkg::cell_mode_t mode;
    logic [W-1:0]         up_in;
    logic [W-1:0]         dn_in;

    if (k == 0) begin : g_up_top
      assign up_in = stk_data;
    end else begin : g_up_mid
      assign up_in = cell_q[k-1];
    end

    if (k == STACK_DEPTH - 1) begin : g_dn_last
      assign dn_in = cell_q[k];
    end else begin : g_dn_mid
      assign dn_in = cell_q[k+1];
    end

    always_comb begin
      case (stk_act)
        ACT_PUSH: mode = smau_pkg::CM_TAKE_UP;
        ACT_POP:  mode = (k == 0) ? smau_pkg::CM_TAKE_UP : smau_pkg::CM_TAKE_DN;
        ACT_SWAP: begin
          if (k == 0) begin
            mode = smau_pkg::CM_TAKE_DN;
          end else if (k == 1) begin
            mode = smau_pkg::CM_TAKE_UP;
          end else begin
            mode = smau_pkg::CM_HOLD;
          end
        end
        default:  mode = smau_pkg::CM_HOLD;
      endcase
    end

    smau_cell u_cell (
      .clk   (clk),
      .mode  (mode),
      .up_in (up_in),
      .dn_in (dn_in),
      .value (cell_q[k])
    );
  end

  smau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (second_a),
    .divisor  (top_b),
    .rsp      (div_rsp)
  );

  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    halted_nxt    = halted_r;
    out_valid_nxt = out_valid_r;
    stk_act       = ACT_HOLD;
    stk_data      = val_r;
    div_start     = 1'b0;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = smau_pkg::ST_OK;
        state_nxt  = S_RESP;
        if (halted_r) begin
          status_nxt = smau_pkg::ST_HALTED;
        end else if (op_r == smau_pkg::OP_PUSH) begin
          if (cnt_r == CW'(STACK_DEPTH)) begin
            status_nxt = smau_pkg::ST_FULL;
            halted_nxt = 1'b1;
          end else begin
            stk_act = ACT_PUSH;
            cnt_nxt = cnt_r + CW'(1);
          end
        end else if (op_r inside {smau_pkg::OP_SUB, smau_pkg::OP_DIV, smau_pkg::OP_MUL,
                                  smau_pkg::OP_MOD, smau_pkg::OP_SWAP}) begin
          if (cnt_r < CW'(2)) begin
            status_nxt = smau_pkg::ST_FEW;
            halted_nxt = 1'b1;
          end else begin
            case (op_r)
              smau_pkg::OP_SWAP: stk_act = ACT_SWAP;
              smau_pkg::OP_SUB: begin
                stk_act  = ACT_POP;
                stk_data = second_a - top_b;
                cnt_nxt  = cnt_r - CW'(1);
              end
              smau_pkg::OP_MUL: state_nxt = S_MUL;
              default: begin
                if (top_b == '0) begin
                  status_nxt = smau_pkg::ST_DIVZERO;
                  halted_nxt = 1'b1;
                end else begin
                  div_start = 1'b1;
                  state_nxt = S_DIV;
                end
              end
            endcase
          end
        end
      end
      S_MUL: begin
        stk_act   = ACT_POP;
        stk_data  = mul_r;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_RESP;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          stk_act   = ACT_POP;
          stk_data  = (op_r == smau_pkg::OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      op_r  <= in_ch.opcode;
      val_r <= $unsigned(in_ch.push_value);
    end
    mul_r <= product;
    if (out_load) begin
      out_status_r <= status_r;
      out_top_r    <= (cnt_r != '0) ? top_b : '0;
      out_count_r  <= cnt_ext[6:0];
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= smau_pkg::ST_OK;
      cnt_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      cnt_r       <= cnt_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.top_value   = $signed(out_top_r);
  assign out_ch.stack_count = out_count_r;

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag dropped without reset");

  // a halted stack never changes depth
  a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> $stable(cnt_r))
    else $error("stack depth changed while halted");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // one instruction moves the depth by at most one entry
  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1) || cnt_r == $past(cnt_r) - CW'(1)))
    else $error("stack depth jumped by more than one");

endmodule

/* tb/tb_stack_machine_arith_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench of the stack machine arithmetic unit: directed table, random, one error
module tb_stack_machine_arith_unit;

  localparam int unsigned WORD_W       = smau_pkg::WORD_W;
  localparam int unsigned OPCODE_W     = smau_pkg::OPCODE_W;
  localparam int unsigned STATUS_W     = smau_pkg::STATUS_W;
  localparam int unsigned COUNT_W      = smau_pkg::COUNT_W;
  localparam int unsigned DEPTH        = smau_pkg::STACK_DEPTH_DEF;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned RANDOM_INSNS = 1500;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CALM_FROM    = 700;
  localparam int unsigned CALM_TO      = 900;
  localparam int unsigned SETTLE       = 60;
  localparam int unsigned N_DIRECTED   = 26;

  // opcodes the block ignores
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic [WORD_W-1:0] W_MIN  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] W_MAX  = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] W_NEG1 = 32'hffff_ffff;

  typedef enum int {FAULT_FULL, FAULT_FEW, FAULT_DIVZERO} fault_kind_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   top;
    logic [COUNT_W-1:0]  count;
  } smau_result_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [WORD_W-1:0]   value;
    logic                typed;
    smau_result_t        res;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{OP_SPARE_7,        32'h0,         1'b1, '{smau_pkg::ST_OK, 32'h0,  7'd0}},
    '{smau_pkg::OP_PUSH, W_MAX,         1'b1, '{smau_pkg::ST_OK, W_MAX,  7'd1}},
    '{smau_pkg::OP_PUSH, W_MIN,         1'b1, '{smau_pkg::ST_OK, W_MIN,  7'd2}},
    '{smau_pkg::OP_SUB,  32'h0,         1'b1, '{smau_pkg::ST_OK, W_NEG1, 7'd1}},
    '{smau_pkg::OP_PUSH, W_MIN,         1'b1, '{smau_pkg::ST_OK, W_MIN,  7'd2}},
    '{smau_pkg::OP_PUSH, W_NEG1,        1'b1, '{smau_pkg::ST_OK, W_NEG1, 7'd3}},
    '{smau_pkg::OP_DIV,  32'h0,         1'b1, '{smau_pkg::ST_OK, W_MIN,  7'd2}},
    '{smau_pkg::OP_PUSH, W_NEG1,        1'b0, '0},
    '{smau_pkg::OP_MOD,  32'h0,         1'b1, '{smau_pkg::ST_OK, 32'h0,  7'd2}},
    '{smau_pkg::OP_SWAP, 32'h0,         1'b1, '{smau_pkg::ST_OK, W_NEG1, 7'd2}},
    '{OP_SPARE_6,        32'h5,         1'b1, '{smau_pkg::ST_OK, W_NEG1, 7'd2}},
    '{smau_pkg::OP_PUSH, 32'hffff_fff9, 1'b0, '0},
    '{smau_pkg::OP_PUSH, 32'h2,         1'b0, '0},
    '{smau_pkg::OP_MOD,  32'h0,         1'b0, '0},
    '{smau_pkg::OP_PUSH, 32'h7,         1'b0, '0},
    '{smau_pkg::OP_PUSH, 32'hffff_fffe, 1'b0, '0},
    '{smau_pkg::OP_DIV,  32'h0,         1'b0, '0},
    '{smau_pkg::OP_PUSH, 32'h7,         1'b0, '0},
    '{smau_pkg::OP_PUSH, 32'hffff_fffe, 1'b0, '0},
    '{smau_pkg::OP_MOD,  32'h0,         1'b0, '0},
    '{smau_pkg::OP_PUSH, 32'h0001_0000, 1'b0, '0},
    '{smau_pkg::OP_PUSH, 32'h0001_0000, 1'b0, '0},
    '{smau_pkg::OP_MUL,  32'h0,         1'b0, '0},
    '{smau_pkg::OP_SUB,  32'h0,         1'b0, '0},
    '{smau_pkg::OP_PUSH, W_MAX,         1'b0, '0},
    '{smau_pkg::OP_MUL,  32'h0,         1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  always #2 clk = ~clk;

  smau_in_if  in_ch();
  smau_out_if out_ch();

  stack_machine_arith_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted stack state
  logic [WORD_W-1:0] stack_words [DEPTH];
  int unsigned       stack_depth = 0;
  bit                stack_halted = 1'b0;

  smau_result_t pending_results[$];
  smau_result_t expected_res;
  int unsigned  mismatches = 0;
  int unsigned  insns_issued = 0;
  bit           calm = 1'b0;
  bit           climbing = 1'b0;
  int unsigned  climb_target = 0;

  function automatic smau_result_t apply_insn(logic [OPCODE_W-1:0] op,
                                              logic [WORD_W-1:0] value);
    smau_result_t      r;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    longint            sa;
    longint            sb;
    longint            q;
    r.status = smau_pkg::ST_OK;
    if (stack_halted) begin
      r.status = smau_pkg::ST_HALTED;
    end else if (op == smau_pkg::OP_PUSH) begin
      if (stack_depth >= DEPTH) begin
        r.status = smau_pkg::ST_FULL;
      end else begin
        stack_words[stack_depth] = value;
        stack_depth++;
      end
    end else if (op <= smau_pkg::OP_SWAP) begin
      if (stack_depth < 2) begin
        r.status = smau_pkg::ST_FEW;
      end else begin
        b = stack_words[stack_depth-1];
        a = stack_words[stack_depth-2];
        // 64-bit so that min / -1 cannot trap
        sa = longint'(signed'(a));
        sb = longint'(signed'(b));
        if (op == smau_pkg::OP_SWAP) begin
          stack_words[stack_depth-1] = a;
          stack_words[stack_depth-2] = b;
        end else if ((op == smau_pkg::OP_DIV || op == smau_pkg::OP_MOD) && b == '0) begin
          r.status = smau_pkg::ST_DIVZERO;
        end else begin
          case (op)
            smau_pkg::OP_SUB: q = longint'(a - b);
            smau_pkg::OP_MUL: q = longint'(a * b);
            smau_pkg::OP_DIV: q = sa / sb;
            default:          q = sa % sb;
          endcase
          stack_words[stack_depth-2] = q[WORD_W-1:0];
          stack_depth--;
        end
      end
    end
    if (r.status != smau_pkg::ST_OK && r.status != smau_pkg::ST_HALTED) stack_halted = 1'b1;
    r.top = (stack_depth > 0) ? stack_words[stack_depth-1] : '0;
    r.count = COUNT_W'(stack_depth);
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 19)) inside
      [0:4]: return WORD_W'($urandom_range(0, 32)) - 32'd16;
      5: return W_MIN;
      6: return W_MAX;
      7: return W_NEG1;
      8: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_binary_op();
    case ($urandom_range(0, 4))
      0: return smau_pkg::OP_SUB;
      1: return smau_pkg::OP_DIV;
      2: return smau_pkg::OP_MUL;
      3: return smau_pkg::OP_MOD;
      default: return smau_pkg::OP_SWAP;
    endcase
  endfunction

  // error-free instruction; depth climbs to a target, then drains
  task automatic pick_random_insn(output logic [OPCODE_W-1:0] op,
                                  output logic [WORD_W-1:0] value);
    int unsigned r;
    r = $urandom_range(0, 99);
    value = random_word();
    if (climbing && stack_depth >= climb_target) begin
      climbing = 1'b0;
    end else if (!climbing && stack_depth <= 2) begin
      climbing = 1'b1;
      climb_target = ($urandom_range(0, 9) == 0) ? DEPTH : $urandom_range(3, 20);
    end
    if (r < 3) begin
      op = r[0] ? OP_SPARE_6 : OP_SPARE_7;
    end else if (stack_depth < 2 ||
                 (stack_depth < DEPTH && $urandom_range(0, 99) < (climbing ? 75 : 20))) begin
      op = smau_pkg::OP_PUSH;
    end else begin
      op = pick_binary_op();
      if ((op == smau_pkg::OP_DIV || op == smau_pkg::OP_MOD) &&
          stack_words[stack_depth-1] == '0) op = smau_pkg::OP_SUB;
    end
  endtask

  task automatic issue_insn(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] value,
                            input bit typed, input smau_result_t typed_res);
    smau_result_t r;
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.push_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_insn(op, value);
    pending_results.push_back(typed ? typed_res : r);
    insns_issued <= insns_issued + 1;
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result receiver with one long hold-off so the block backs up
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && insns_issued >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual status %0d top %h count %0d",
                 $time, out_ch.status, out_ch.top_value, out_ch.stack_count);
        mismatches++;
      end else begin
        expected_res = pending_results.pop_front();
        check_field("status", WORD_W'(expected_res.status), WORD_W'(out_ch.status));
        check_field("top_value", expected_res.top, out_ch.top_value);
        check_field("stack_count", WORD_W'(expected_res.count), WORD_W'(out_ch.stack_count));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [OPCODE_W-1:0] op;
    logic [WORD_W-1:0]   value;
    fault_kind_t         fault;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= smau_pkg::OP_PUSH;
    in_ch.push_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      issue_insn(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                 DIRECTED_ROWS[i].res);
    end

    for (int i = 0; i < RANDOM_INSNS; i++) begin
      calm <= (i >= CALM_FROM && i < CALM_TO);
      pick_random_insn(op, value);
      issue_insn(op, value, 1'b0, '0);
    end

    // the halt is sticky, so exactly one error kind is reached per run
    fault = fault_kind_t'($urandom_range(0, 2));
    case (fault)
      FAULT_FULL: begin
        while (!stack_halted) issue_insn(smau_pkg::OP_PUSH, random_word(), 1'b0, '0);
      end
      FAULT_FEW: begin
        while (!stack_halted) begin
          issue_insn((stack_depth >= 2) ? smau_pkg::OP_SUB : pick_binary_op(), $urandom(),
                     1'b0, '0);
        end
      end
      default: begin
        while (stack_depth >= DEPTH - 1) issue_insn(smau_pkg::OP_SUB, $urandom(), 1'b0, '0);
        if (stack_depth == 0) issue_insn(smau_pkg::OP_PUSH, random_word(), 1'b0, '0);
        issue_insn(smau_pkg::OP_PUSH, '0, 1'b0, '0);
        issue_insn($urandom_range(0, 1) ? smau_pkg::OP_DIV : smau_pkg::OP_MOD, $urandom(),
                   1'b0, '0);
      end
    endcase
    repeat (8) issue_insn(OPCODE_W'($urandom_range(0, 7)), $urandom(), 1'b0, '0);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
sv/smau_pkg.sv
sv/smau_if.sv
sv/smau_cell.sv
sv/smau_div.sv
sv/stack_machine_arith_unit.sv
tb/tb_stack_machine_arith_unit.sv
